// ----- src/idel_pkg.sv -----
// shared types and constants for the indexed double ended list
package idel_pkg;

	localparam int Capacity  = 256;
	localparam int DataWidth = 32;
	localparam int SlotW     = $clog2(Capacity);
	localparam int CountW    = $clog2(Capacity + 1);

	typedef logic [SlotW-1:0]     slot_t;
	typedef logic [CountW-1:0]    count_t;
	typedef logic [DataWidth-1:0] data_t;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_READ       = 3'd4,
		OP_INSERT     = 3'd5,
		OP_REMOVE     = 3'd6,
		OP_NONE       = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		FSM_INIT,
		FSM_IDLE,
		FSM_WALK,
		FSM_WALK_WAIT,
		FSM_RD_LINKS,
		FSM_RD_WAIT,
		FSM_EXEC,
		FSM_REPLY
	} fsm_t;

	// write bundle for the link and value memories
	typedef struct packed {
		logic  nxt_we;
		slot_t nxt_addr;
		slot_t nxt_data;
		logic  nxt2_we;
		slot_t nxt2_addr;
		slot_t nxt2_data;
		logic  prv_we;
		slot_t prv_addr;
		slot_t prv_data;
		logic  prv2_we;
		slot_t prv2_addr;
		slot_t prv2_data;
		logic  val_we;
		slot_t val_addr;
		data_t val_data;
	} mem_wr_t;

endpackage

// ----- src/idel_store.sv -----
// node memories: values, next links and previous links
module idel_store (
	input  logic             clk,
	input  idel_pkg::mem_wr_t wr,
	input  idel_pkg::slot_t  rd_addr,
	output idel_pkg::slot_t  rd_next,
	output idel_pkg::slot_t  rd_prev,
	output idel_pkg::data_t  rd_value
);

	idel_pkg::slot_t next_mem [idel_pkg::Capacity];
	idel_pkg::slot_t prev_mem [idel_pkg::Capacity];
	idel_pkg::data_t val_mem  [idel_pkg::Capacity];

	// two write ports per link memory, one read port each
	always_ff @(posedge clk) begin
		if (wr.nxt_we) next_mem[wr.nxt_addr] <= wr.nxt_data;
		if (wr.nxt2_we) next_mem[wr.nxt2_addr] <= wr.nxt2_data;
		if (wr.prv_we) prev_mem[wr.prv_addr] <= wr.prv_data;
		if (wr.prv2_we) prev_mem[wr.prv2_addr] <= wr.prv2_data;
		if (wr.val_we) val_mem[wr.val_addr] <= wr.val_data;
		rd_next  <= next_mem[rd_addr];
		rd_prev  <= prev_mem[rd_addr];
		rd_value <= val_mem[rd_addr];
	end

endmodule

// ----- src/idel_free.sv -----
// free slot stack memory
module idel_free (
	input  logic            clk,
	input  logic            we,
	input  idel_pkg::slot_t waddr,
	input  idel_pkg::slot_t wdata,
	input  idel_pkg::slot_t raddr,
	output idel_pkg::slot_t rdata
);

	idel_pkg::slot_t mem [idel_pkg::Capacity];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ----- src/indexed_double_ended_list.sv -----
// top level of the indexed double ended list
//
// channel   dir  fields (lsb first)                          handshake
// s_axis    in   tdata: op[2:0] position[10:3] value[42:11]   s_axis_tvalid/tready
// m_axis    out  tdata: read_value[31:0] status[33:32]        m_axis_tvalid/tready
//                length[42:34]
//
// after reset a clearing pass fills the free stack with slot numbers
// read, insert and remove inside the list walk as many nodes as the position; every
// other request walks none. A new request is taken only once the previous result has
// gone; a stalled result holds the input off until taken
module indexed_double_ended_list (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // op, position, value, zero fill
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // read_value, status, length, zero fill
);

	localparam int SW = idel_pkg::SlotW;
	localparam int CW = idel_pkg::CountW;

	idel_pkg::fsm_t    state_q, state_d;
	idel_pkg::op_t     op_q;
	logic [7:0]        pos_q;
	logic [7:0]        goal_q;
	idel_pkg::data_t   val_q;
	idel_pkg::slot_t   first_q, last_q, cur_q;
	idel_pkg::count_t  count_q, free_top_q, step_q;
	idel_pkg::count_t  init_q;
	idel_pkg::data_t   rd_q;
	idel_pkg::status_t st_q;

	idel_pkg::mem_wr_t wr;
	idel_pkg::slot_t   rd_addr, rd_next, rd_prev;
	idel_pkg::data_t   rd_value;
	logic              fr_we;
	idel_pkg::slot_t   fr_waddr, fr_wdata, fr_raddr, fr_rdata;

	idel_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_next (rd_next),
		.rd_prev (rd_prev),
		.rd_value(rd_value)
	);

	idel_free u_free (
		.clk  (clk),
		.we   (fr_we),
		.waddr(fr_waddr),
		.wdata(fr_wdata),
		.raddr(fr_raddr),
		.rdata(fr_rdata)
	);

	logic full, in_acc, out_acc;
	assign full = (free_top_q == '0) || (count_q >= CW'(idel_pkg::Capacity));
	assign s_axis_tready = (state_q == idel_pkg::FSM_IDLE);
	assign m_axis_tvalid = (state_q == idel_pkg::FSM_REPLY);
	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata = {5'd0, count_q, st_q, rd_q};

	// incoming item: only positional requests inside the list walk the links
	idel_pkg::op_t in_op;
	logic [7:0]    in_pos;
	logic          walk_in;
	assign in_op   = idel_pkg::op_t'(s_axis_tdata[2:0]);
	assign in_pos  = s_axis_tdata[10:3];
	assign walk_in = (in_op inside {idel_pkg::OP_READ, idel_pkg::OP_INSERT,
		idel_pkg::OP_REMOVE}) && (CW'(in_pos) < count_q);

	// target slot: cur_q after the walk, or an end slot
	logic pos_is_end, pos_zero;
	assign pos_zero   = (pos_q == 8'd0);
	assign pos_is_end = (CW'(pos_q) == count_q);

	// free stack read address is always the top entry below free_top
	assign fr_raddr = SW'(free_top_q - CW'(1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			idel_pkg::FSM_INIT:
				if (init_q == CW'(idel_pkg::Capacity - 1)) state_d = idel_pkg::FSM_IDLE;
			idel_pkg::FSM_IDLE:
				if (in_acc) state_d = idel_pkg::FSM_WALK_WAIT;
			idel_pkg::FSM_WALK:
				// links of cur_q are valid here; stop or step to the next node
				if (step_q == CW'(goal_q)) state_d = idel_pkg::FSM_RD_LINKS;
				else state_d = idel_pkg::FSM_WALK_WAIT;
			idel_pkg::FSM_WALK_WAIT: state_d = idel_pkg::FSM_WALK;
			idel_pkg::FSM_RD_LINKS: state_d = idel_pkg::FSM_RD_WAIT;
			idel_pkg::FSM_RD_WAIT: state_d = idel_pkg::FSM_EXEC;
			idel_pkg::FSM_EXEC: state_d = idel_pkg::FSM_REPLY;
			idel_pkg::FSM_REPLY:
				if (out_acc) state_d = idel_pkg::FSM_IDLE;
			default: state_d = idel_pkg::FSM_IDLE;
		endcase
	end

	// memory read address follows the current node
	assign rd_addr = cur_q;

	// execute stage: rd_next/rd_prev/rd_value belong to cur_q
	logic            do_exec;
	idel_pkg::slot_t news, p, n;
	assign do_exec = (state_q == idel_pkg::FSM_EXEC);
	assign news = fr_rdata;
	assign p = rd_prev;
	assign n = rd_next;

	logic ins_front, ins_back, ins_mid, rem, push_ok, rem_ok;
	idel_pkg::status_t st_d;
	always_comb begin
		st_d = idel_pkg::ST_OK;
		ins_front = 1'b0; ins_back = 1'b0; ins_mid = 1'b0; rem = 1'b0;
		case (op_q)
			idel_pkg::OP_PUSH_FRONT, idel_pkg::OP_PUSH_BACK: begin
				if (full) st_d = idel_pkg::ST_FULL;
				else if (op_q == idel_pkg::OP_PUSH_FRONT) ins_front = 1'b1;
				else ins_back = 1'b1;
			end
			idel_pkg::OP_POP_FRONT, idel_pkg::OP_POP_BACK: begin
				if (count_q == '0) st_d = idel_pkg::ST_EMPTY;
				else rem = 1'b1;
			end
			idel_pkg::OP_READ:
				if (CW'(pos_q) >= count_q) st_d = idel_pkg::ST_RANGE;
			idel_pkg::OP_INSERT: begin
				if (CW'(pos_q) > count_q) st_d = idel_pkg::ST_RANGE;
				else if (full) st_d = idel_pkg::ST_FULL;
				else if (pos_zero) ins_front = 1'b1;
				else if (pos_is_end) ins_back = 1'b1;
				else ins_mid = 1'b1;
			end
			idel_pkg::OP_REMOVE:
				if (CW'(pos_q) >= count_q) st_d = idel_pkg::ST_RANGE;
				else rem = 1'b1;
			default: st_d = idel_pkg::ST_OK;
		endcase
	end
	assign push_ok = ins_front || ins_back || ins_mid;
	assign rem_ok  = rem;

	always_comb begin
		wr = '0;
		fr_we = 1'b0;
		fr_waddr = SW'(free_top_q);
		fr_wdata = cur_q;
		if (state_q == idel_pkg::FSM_INIT) begin
			fr_we    = 1'b1;
			fr_waddr = SW'(init_q);
			fr_wdata = SW'(init_q);
		end else if (do_exec) begin
			if (push_ok) begin
				wr.val_we = 1'b1; wr.val_addr = news; wr.val_data = val_q;
			end
			if (ins_front && count_q != '0) begin
				wr.nxt_we = 1'b1; wr.nxt_addr = news; wr.nxt_data = first_q;
				wr.prv_we = 1'b1; wr.prv_addr = first_q; wr.prv_data = news;
			end
			if (ins_back && count_q != '0) begin
				wr.prv_we = 1'b1; wr.prv_addr = news; wr.prv_data = last_q;
				wr.nxt_we = 1'b1; wr.nxt_addr = last_q; wr.nxt_data = news;
			end
			if (ins_mid) begin
				wr.nxt_we  = 1'b1; wr.nxt_addr  = p;    wr.nxt_data  = news;
				wr.nxt2_we = 1'b1; wr.nxt2_addr = news; wr.nxt2_data = cur_q;
				wr.prv_we  = 1'b1; wr.prv_addr  = news; wr.prv_data  = p;
				wr.prv2_we = 1'b1; wr.prv2_addr = cur_q; wr.prv2_data = news;
			end
			if (rem_ok) begin
				fr_we = 1'b1;
				if (count_q > CW'(1)) begin
					if (cur_q != first_q) begin
						wr.nxt_we = 1'b1; wr.nxt_addr = p; wr.nxt_data = n;
					end
					if (cur_q != last_q) begin
						wr.prv_we = 1'b1; wr.prv_addr = n; wr.prv_data = p;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= idel_pkg::FSM_INIT;
			init_q     <= '0;
			first_q    <= '0;
			last_q     <= '0;
			count_q    <= '0;
			free_top_q <= CW'(idel_pkg::Capacity);
		end else begin
			state_q <= state_d;
			if (state_q == idel_pkg::FSM_INIT) init_q <= init_q + CW'(1);
			if (do_exec) begin
				if (push_ok) begin
					free_top_q <= free_top_q - CW'(1);
					count_q    <= count_q + CW'(1);
					if (count_q == '0) begin
						first_q <= news; last_q <= news;
					end else if (ins_front) first_q <= news;
					else if (ins_back) last_q <= news;
				end
				if (rem_ok) begin
					free_top_q <= free_top_q + CW'(1);
					count_q    <= count_q - CW'(1);
					if (count_q <= CW'(1)) begin
						first_q <= '0; last_q <= '0;
					end else begin
						if (cur_q == first_q) first_q <= n;
						if (cur_q == last_q) last_q <= p;
					end
				end
			end
		end
	end

	// payload and walk registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= in_op;
			pos_q  <= in_pos;
			val_q  <= s_axis_tdata[42:11];
			goal_q <= walk_in ? in_pos : 8'd0;
			step_q <= '0;
			// end ops never walk: point at the end slot directly
			if (in_op == idel_pkg::OP_POP_BACK) cur_q <= last_q;
			else cur_q <= first_q;
		end
		if (state_q == idel_pkg::FSM_WALK && step_q != CW'(goal_q)) begin
			step_q <= step_q + CW'(1);
			cur_q  <= rd_next;
		end
		if (do_exec) begin
			st_q <= st_d;
			rd_q <= (op_q == idel_pkg::OP_READ && st_d == idel_pkg::ST_OK) ? rd_value : '0;
		end
	end

endmodule

// ----- sim/testbench.sv -----
// testbench for the indexed double ended list: directed and random list requests
`timescale 1ns / 100ps

module testbench;

	localparam int LimitCycles = 4000000;
	localparam int Depth       = idel_pkg::Capacity;
	localparam int RingSize    = 16;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;   // op, position, value, zero fill
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;   // read_value, status, length, zero fill

	// list contents kept in order, front at index 0
	logic [31:0] model_q [Depth];
	int          model_len;

	// expected answers in order: length, status, read_value from the top bit down
	logic [42:0] want_ring [RingSize];
	int          wr_cnt;
	int          rd_cnt = 0;

	int  mismatches = 0;
	int  cycles = 0;
	int  send_idle_pct;
	int  stall_pct;

	indexed_double_ended_list uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// opens a gap at index at and stores v there
	function automatic void model_add(int at, logic [31:0] v);
		for (int i = model_len; i > at; i--) model_q[i] = model_q[i-1];
		model_q[at] = v;
		model_len++;
	endfunction

	// closes the gap left by the element at index at
	function automatic void model_drop(int at);
		for (int i = at; i < model_len - 1; i++) model_q[i] = model_q[i+1];
		model_len--;
	endfunction

	// predicts one answer and updates the list contents
	function automatic logic [42:0] list_answer(idel_pkg::op_t op, logic [7:0] pos,
		logic [31:0] val);
		logic [31:0]       rd;
		idel_pkg::status_t st;
		int                n;
		n  = model_len;
		rd = '0;
		st = idel_pkg::ST_OK;
		case (op)
			idel_pkg::OP_PUSH_FRONT, idel_pkg::OP_PUSH_BACK: begin
				if (n >= Depth) st = idel_pkg::ST_FULL;
				else if (op == idel_pkg::OP_PUSH_FRONT) model_add(0, val);
				else model_add(n, val);
			end
			idel_pkg::OP_POP_FRONT, idel_pkg::OP_POP_BACK: begin
				if (n == 0) st = idel_pkg::ST_EMPTY;
				else if (op == idel_pkg::OP_POP_FRONT) model_drop(0);
				else model_drop(n - 1);
			end
			idel_pkg::OP_READ: begin
				if (int'(pos) >= n) st = idel_pkg::ST_RANGE;
				else rd = model_q[pos];
			end
			idel_pkg::OP_INSERT: begin
				if (int'(pos) > n) st = idel_pkg::ST_RANGE;
				else if (n >= Depth) st = idel_pkg::ST_FULL;
				else model_add(int'(pos), val);
			end
			idel_pkg::OP_REMOVE: begin
				if (int'(pos) >= n) st = idel_pkg::ST_RANGE;
				else model_drop(int'(pos));
			end
			default: ;
		endcase
		return {9'(model_len), st, rd};
	endfunction

	// sends one item and records its expected answer once accepted
	task automatic send_item(idel_pkg::op_t op, logic [7:0] pos, logic [31:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'd0, val, pos, op};
		@(negedge clk);
		while (!s_axis_tready) @(negedge clk);
		@(posedge clk);
		want_ring[wr_cnt % RingSize] = list_answer(op, pos, val);
		wr_cnt++;
	endtask

	// holds the sender off until every expected answer has come
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (wr_cnt != rd_cnt) @(posedge clk);
	endtask

	// receiver stalls at random
	always @(posedge clk) begin
		if (!arst_n) m_axis_tready <= 1'b0;
		else m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// checks each answer against the oldest prediction
	always @(posedge clk) begin
		logic [42:0] want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (rd_cnt == wr_cnt) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item %h", m_axis_tdata);
			end else begin
				want = want_ring[rd_cnt % RingSize];
				rd_cnt++;
				if (m_axis_tdata !== {5'd0, want}) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: want value %h status %0d length %0d, got %h %0d %0d",
							want[31:0], want[33:32], want[42:34],
							m_axis_tdata[31:0], m_axis_tdata[33:32], m_axis_tdata[42:34]);
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles == LimitCycles) begin
			$display("testbench: errors");
			$finish;
		end
	end

	task automatic test_directed();
		send_item(idel_pkg::OP_POP_FRONT, 8'd0, 32'd0);      // pop on empty
		send_item(idel_pkg::OP_POP_BACK, 8'd0, 32'd0);
		send_item(idel_pkg::OP_READ, 8'd0, 32'd0);           // read on empty
		send_item(idel_pkg::OP_REMOVE, 8'd0, 32'd0);
		send_item(idel_pkg::OP_INSERT, 8'd1, 32'd5);         // insert past end
		send_item(idel_pkg::OP_INSERT, 8'd0, 32'h8000_0000);
		send_item(idel_pkg::OP_PUSH_FRONT, 8'hff, 32'h7fff_ffff);
		send_item(idel_pkg::OP_PUSH_BACK, 8'd0, 32'hffff_ffff);
		send_item(idel_pkg::OP_INSERT, 8'd3, 32'h1234_5678); // append
		send_item(idel_pkg::OP_INSERT, 8'd2, 32'h0);         // middle
		send_item(idel_pkg::OP_READ, 8'd4, 32'd0);
		send_item(idel_pkg::OP_READ, 8'd5, 32'd0);
		send_item(idel_pkg::OP_REMOVE, 8'd2, 32'd0);
		send_item(idel_pkg::OP_NONE, 8'hff, 32'hffff_ffff);
		send_item(idel_pkg::OP_POP_FRONT, 8'd5, 32'd0);      // position ignored
		send_item(idel_pkg::OP_POP_BACK, 8'd7, 32'd0);
		send_item(idel_pkg::OP_REMOVE, 8'd1, 32'd0);
		send_item(idel_pkg::OP_REMOVE, 8'd0, 32'd0);
		send_item(idel_pkg::OP_PUSH_BACK, 8'd0, 32'h5a5a_a5a5);
		send_item(idel_pkg::OP_POP_FRONT, 8'd0, 32'd0);      // pop of last element
		send_item(idel_pkg::OP_READ, 8'd0, 32'd0);
		wait_drained();
	endtask

	// fills the store to capacity and beyond, then walks the far end
	task automatic test_full();
		while (model_len < Depth) send_item(idel_pkg::OP_PUSH_BACK, 8'd0, $urandom());
		send_item(idel_pkg::OP_PUSH_FRONT, 8'd0, $urandom());
		send_item(idel_pkg::OP_INSERT, 8'd255, $urandom());
		send_item(idel_pkg::OP_READ, 8'd255, 32'd0);
		send_item(idel_pkg::OP_REMOVE, 8'd255, 32'd0);
		send_item(idel_pkg::OP_INSERT, 8'd255, $urandom());
		send_item(idel_pkg::OP_INSERT, 8'd0, $urandom());
		while (model_len > 8)
			send_item(idel_pkg::op_t'(3'($urandom_range(3, 2))), 8'd0, 32'd0);
		wait_drained();
	endtask

	// random requests; positions mostly inside the list, lengths kept small
	task automatic test_random(int count);
		idel_pkg::op_t op;
		logic [7:0]    pos;
		for (int i = 0; i < count; i++) begin
			op = idel_pkg::op_t'(3'($urandom_range(7)));
			if (op == idel_pkg::OP_NONE && $urandom_range(3) != 0) op = idel_pkg::OP_READ;
			if (model_len > 40 && $urandom_range(1) == 1)
				op = idel_pkg::op_t'(3'($urandom_range(3, 2)));
			if ($urandom_range(9) == 0) pos = 8'($urandom());
			else pos = 8'($urandom_range(model_len + 1));
			send_item(op, pos, $urandom());
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		model_len = 0;
		wr_cnt = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_full();
		test_random(200);
		send_idle_pct = 82;
		test_random(150);
		send_idle_pct = 0;
		stall_pct = 82;
		test_random(150);
		send_idle_pct = 12;
		stall_pct = 12;
		test_random(150);
		send_idle_pct = 0;
		stall_pct = 0;
		test_random(90);

		repeat (50) @(posedge clk);
		if (mismatches == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/idel_pkg.sv
src/idel_store.sv
src/idel_free.sv
src/indexed_double_ended_list.sv
sim/testbench.sv
